### hdl/tcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, constants and helpers for the text console cursor/scroll block.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int MAX_ROWS = 25;
    localparam int MAX_COLS = 80;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(CELLS);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 7;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'd10;

    localparam logic [ROW_W-1:0] RESET_ROWS = ROW_W'(MAX_ROWS);
    localparam logic [COL_W-1:0] RESET_COLS = COL_W'(MAX_COLS);

    typedef enum logic [CMD_W-1:0] {
        CMD_PRINT = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    // Packed lowest field last: cursor_row occupies the low bits.
    typedef struct packed {
        logic                scrolled;
        logic [CHAR_W-1:0]   cell_attr;
        logic [CHAR_W-1:0]   cell_char;
        logic [POS_W-1:0]    cursor_position;
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
    } result_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

    function automatic logic [POS_W-1:0] cursor_pos(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] rows,
                                                    input logic [COL_W-1:0] cols);
        logic [ROW_W-1:0] pr;
        logic [COL_W-1:0] pc;
        pr = (row >= rows) ? rows - 1'b1 : row;
        pc = (col >= cols) ? cols - 1'b1 : col;
        return POS_W'(int'(pr) * MAX_COLS + int'(pc));
    endfunction

endpackage
`default_nettype wire

### hdl/tcc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/tcc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_ctrl
// Cursor state and cell-store sequencer: print, scroll, clear, read, init.
// ----------------------------------------------------------------------------
module tcc_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tcc_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic [23:0]                   s_tdata,
    input  wire logic [tcc_pkg::ROW_W-1:0]     rows_in_use,
    input  wire logic [tcc_pkg::COL_W-1:0]     cols_in_use,
    output logic                               wr_en,
    output logic [tcc_pkg::ADDR_W-1:0]         wr_addr,
    output logic [tcc_pkg::CELL_W-1:0]         wr_data,
    output logic                               rd_en,
    output logic [tcc_pkg::ADDR_W-1:0]         rd_addr,
    input  wire logic [tcc_pkg::CELL_W-1:0]    rd_data,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output tcc_pkg::result_t                   res
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_PUT,
        ST_RESULT
    } state_t;

    state_t                          state_reg, state_next;
    logic [tcc_pkg::ROW_W-1:0]       row_reg, row_next;
    logic [tcc_pkg::COL_W-1:0]       col_reg, col_next;
    logic [tcc_pkg::ROW_W-1:0]       y_reg, y_next;
    logic [tcc_pkg::COL_W-1:0]       x_reg, x_next;
    logic [tcc_pkg::ADDR_W-1:0]      init_addr_reg, init_addr_next;
    logic                            scrolled_reg, scrolled_next;
    logic                            pend_reg, pend_next;
    logic [tcc_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                            rd_ok_reg, rd_ok_next;
    logic [tcc_pkg::CELL_W-1:0]      cell_reg, cell_next;
    logic                            copy_vld_reg, copy_vld_next;
    logic [tcc_pkg::ADDR_W-1:0]      copy_addr_reg, copy_addr_next;

    tcc_pkg::cmd_t                   cmd;
    logic [tcc_pkg::CHAR_W-1:0]      ch;
    logic [tcc_pkg::ROW_W-1:0]       rr;
    logic [tcc_pkg::COL_W-1:0]       rc;
    logic [tcc_pkg::ROW_W-1:0]       rows_eff;
    logic [tcc_pkg::COL_W-1:0]       cols_eff;
    logic [tcc_pkg::ROW_W-1:0]       last_row;
    logic [tcc_pkg::COL_W-1:0]       last_col;
    logic [tcc_pkg::ROW_W:0]         row_inc;
    logic                            past_end;
    logic                            accept;

    assign cmd = tcc_pkg::cmd_t'(s_tuser);
    assign ch  = s_tdata[7:0];
    assign rr  = s_tdata[12:8];
    assign rc  = s_tdata[19:13];

    always_comb
    begin
        if (rows_in_use < tcc_pkg::ROW_W'(2))
            rows_eff = tcc_pkg::ROW_W'(2);
        else if (rows_in_use > tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS))
            rows_eff = tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS);
        else
            rows_eff = rows_in_use;

        if (cols_in_use == '0)
            cols_eff = tcc_pkg::COL_W'(1);
        else if (cols_in_use > tcc_pkg::COL_W'(tcc_pkg::MAX_COLS))
            cols_eff = tcc_pkg::COL_W'(tcc_pkg::MAX_COLS);
        else
            cols_eff = cols_in_use;
    end

    assign last_row = rows_eff - 1'b1;
    assign last_col = cols_eff - 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign past_end = row_inc >= {1'b0, rows_eff};
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        init_addr_next = init_addr_reg;
        scrolled_next  = scrolled_reg;
        pend_next      = pend_reg;
        char_next      = char_reg;
        rd_ok_next     = rd_ok_reg;
        cell_next      = cell_reg;
        copy_vld_next  = 1'b0;
        copy_addr_next = copy_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = tcc_pkg::BLANK_CELL;
        rd_en          = 1'b0;
        rd_addr        = '0;
        res_valid      = 1'b0;

        // complete the copy issued last cycle
        if (copy_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end

        case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = init_addr_reg;
                if (init_addr_reg == tcc_pkg::ADDR_W'(tcc_pkg::CELLS - 1))
                    state_next = ST_IDLE;
                else
                    init_addr_next = init_addr_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    pend_next     = 1'b0;
                    cell_next     = '0;
                    char_next     = ch;
                    state_next    = ST_RESULT;
                    case (cmd)
                        tcc_pkg::CMD_PRINT:
                        begin
                            if (ch == tcc_pkg::NEWLINE || col_reg >= cols_eff)
                            begin
                                col_next = '0;
                                if (past_end)
                                begin
                                    scrolled_next = 1'b1;
                                    pend_next     = (ch != tcc_pkg::NEWLINE);
                                    row_next      = last_row;
                                    x_next        = '0;
                                    if (rows_eff > tcc_pkg::ROW_W'(2))
                                    begin
                                        y_next     = tcc_pkg::ROW_W'(2);
                                        state_next = ST_COPY;
                                    end
                                    else
                                    begin
                                        y_next     = last_row;
                                        state_next = ST_BLANK;
                                    end
                                end
                                else
                                begin
                                    row_next = row_inc[tcc_pkg::ROW_W-1:0];
                                    if (ch != tcc_pkg::NEWLINE)
                                    begin
                                        wr_en    = 1'b1;
                                        wr_addr  = tcc_pkg::cell_addr(
                                                       row_inc[tcc_pkg::ROW_W-1:0], '0);
                                        wr_data  = {tcc_pkg::TEXT_ATTR, ch};
                                        col_next = tcc_pkg::COL_W'(1);
                                    end
                                end
                            end
                            else if (row_reg < rows_eff)
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = tcc_pkg::cell_addr(row_reg, col_reg);
                                wr_data  = {tcc_pkg::TEXT_ATTR, ch};
                                col_next = col_reg + 1'b1;
                            end
                        end
                        tcc_pkg::CMD_CLEAR:
                        begin
                            row_next   = tcc_pkg::ROW_W'(1);
                            col_next   = '0;
                            y_next     = tcc_pkg::ROW_W'(1);
                            x_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        tcc_pkg::CMD_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_ok_next = (rr < tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS)) &&
                                         (rc < tcc_pkg::COL_W'(tcc_pkg::MAX_COLS));
                            rd_addr    = rd_ok_next ? tcc_pkg::cell_addr(rr, rc) : '0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                cell_next  = rd_ok_reg ? rd_data : '0;
                state_next = ST_RESULT;
            end

            ST_COPY:
            begin
                rd_en          = 1'b1;
                rd_addr        = tcc_pkg::cell_addr(y_reg, x_reg);
                copy_vld_next  = 1'b1;
                copy_addr_next = tcc_pkg::cell_addr(y_reg - 1'b1, x_reg);
                if (x_reg == last_col)
                begin
                    x_next = '0;
                    if (y_reg == last_row)
                        state_next = ST_DRAIN;
                    else
                        y_next = y_reg + 1'b1;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                y_next     = last_row;
                x_next     = '0;
                state_next = ST_BLANK;
            end

            ST_BLANK:
            begin
                wr_en   = 1'b1;
                wr_addr = tcc_pkg::cell_addr(y_reg, x_reg);
                if (x_reg == last_col)
                    state_next = pend_reg ? ST_PUT : ST_RESULT;
                else
                    x_next = x_reg + 1'b1;
            end

            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = tcc_pkg::cell_addr(y_reg, x_reg);
                if (x_reg == last_col)
                begin
                    x_next = '0;
                    if (y_reg == last_row)
                        state_next = ST_RESULT;
                    else
                        y_next = y_reg + 1'b1;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end

            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = tcc_pkg::cell_addr(row_reg, col_reg);
                wr_data    = {tcc_pkg::TEXT_ATTR, char_reg};
                col_next   = col_reg + 1'b1;
                pend_next  = 1'b0;
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.cursor_row      = row_reg;
        res.cursor_col      = col_reg;
        res.cursor_position = tcc_pkg::cursor_pos(row_reg, col_reg, rows_eff, cols_eff);
        res.cell_char       = cell_reg[7:0];
        res.cell_attr       = cell_reg[15:8];
        res.scrolled        = scrolled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_reg       <= tcc_pkg::ROW_W'(1);
            col_reg       <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            init_addr_reg <= '0;
            scrolled_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            copy_vld_reg  <= 1'b0;
            char_reg      <= '0;
            cell_reg      <= '0;
            copy_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            y_reg         <= y_next;
            x_reg         <= x_next;
            init_addr_reg <= init_addr_next;
            scrolled_reg  <= scrolled_next;
            pend_reg      <= pend_next;
            rd_ok_reg     <= rd_ok_next;
            copy_vld_reg  <= copy_vld_next;
            char_reg      <= char_next;
            cell_reg      <= cell_next;
            copy_addr_reg <= copy_addr_next;
        end
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("read and write hit the same cell in one cycle");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while previous one still in progress");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= tcc_pkg::COL_W'(tcc_pkg::MAX_COLS))
        else $error("cursor column beyond store width");

    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && scrolled_reg) |->
            (row_reg == last_row && col_reg <= tcc_pkg::COL_W'(1)))
        else $error("scroll left cursor away from last row");

endmodule
`default_nettype wire

### hdl/tcc_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_out
// Output register for result requests; frees the sequencer from the receiver.
// ----------------------------------------------------------------------------
module tcc_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire tcc_pkg::result_t  push_data,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata
);

    logic              valid_reg;
    tcc_pkg::result_t  data_reg;

    assign push_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

endmodule
`default_nettype wire

### hdl/text_console_cursor_scroll.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell console with cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// Requests enter on s_t*: s_tuser carries the command (print, clear, read,
// no-op), s_tdata the byte and the cell coordinates for a read. Every request
// yields exactly one result on m_t* with the cursor, its linear position,
// the read cell and a scroll flag.
// Row/column limits are written on cfg_* (index 0 rows, 1 columns); the user
// must write them only while idle, as the block does not enforce it. A read
// waits on the registered RAM port. A scroll walks the store, moving rows up
// when there are three or more rows, then blanking the last row; a wrapped byte is
// written on the new row after that. A clear blanks every row in use from row 1.
// One request is in flight at a time; s_tready is low during the walk.
// After reset the cell store is swept to blanks before the first request is
// taken; the cursor starts at row 1, column 0.
// A stalled receiver holds the result in the output register; the next
// request is still taken and waits for that register before reporting.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,    // command
    input  wire logic [23:0] s_tdata,    // char_code, read_row, read_col, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // cursor_row, cursor_col, cursor_position,
                                         // cell_char, cell_attr, scrolled
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    logic [tcc_pkg::ROW_W-1:0]  rows_reg;
    logic [tcc_pkg::COL_W-1:0]  cols_reg;
    logic                       wr_en;
    logic [tcc_pkg::ADDR_W-1:0] wr_addr;
    logic [tcc_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [tcc_pkg::ADDR_W-1:0] rd_addr;
    logic [tcc_pkg::CELL_W-1:0] rd_data;
    logic                       res_valid;
    logic                       res_ready;
    tcc_pkg::result_t           res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= tcc_pkg::RESET_ROWS;
            cols_reg <= tcc_pkg::RESET_COLS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tcc_pkg::reg_idx_t'(cfg_index))
                tcc_pkg::REG_ROWS: rows_reg <= cfg_data[tcc_pkg::ROW_W-1:0];
                tcc_pkg::REG_COLS: cols_reg <= cfg_data[tcc_pkg::COL_W-1:0];
                default:           rows_reg <= rows_reg;
            endcase
        end
    end

    tcc_ram #(
        .WIDTH (tcc_pkg::CELL_W),
        .DEPTH (tcc_pkg::CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    tcc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_data  (res),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

### tb/tb_text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Self-checking bench for the text console: a local model of the cell store
// and cursor predicts every report, and a monitor compares each one field by
// field. Directed requests cover byte extremes, every command, reads outside
// the store, a cursor stranded below the rows in use, scrolls and clears;
// random phases follow across small, clamped and full-size geometries while
// both stream sides stall at random in all but the last two phases.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;

    typedef struct {
        tcc_pkg::cmd_t                  cmd;
        logic [tcc_pkg::CHAR_W-1:0]     ch;
        logic [tcc_pkg::ROW_W-1:0]      rr;
        logic [tcc_pkg::COL_W-1:0]      rc;
    } console_req_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [1:0]                     s_tuser = tcc_pkg::CMD_NOP;
    logic [23:0]                    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [39:0]                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index = tcc_pkg::REG_ROWS;
    logic [tcc_pkg::CFG_W-1:0]      cfg_data = '0;

    logic [tcc_pkg::CELL_W-1:0]     text_cells [tcc_pkg::MAX_ROWS][tcc_pkg::MAX_COLS];
    int                             cur_row;
    int                             cur_col;
    logic [tcc_pkg::ROW_W-1:0]      rows_cfg;
    logic [tcc_pkg::COL_W-1:0]      cols_cfg;

    console_req_t                   pending_reqs[$];
    tcc_pkg::result_t               expected_reports[$];
    console_req_t                   cur_req;
    int                             outstanding = 0;
    int                             mismatches = 0;
    int                             src_idle_pct = 0;
    int                             sink_idle_pct = 0;

    text_console_cursor_scroll dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int eff_rows();
        int r;
        r = int'(rows_cfg);
        if (r < 2)
            r = 2;
        if (r > tcc_pkg::MAX_ROWS)
            r = tcc_pkg::MAX_ROWS;
        return r;
    endfunction

    function automatic int eff_cols();
        int c;
        c = int'(cols_cfg);
        if (c < 1)
            c = 1;
        if (c > tcc_pkg::MAX_COLS)
            c = tcc_pkg::MAX_COLS;
        return c;
    endfunction

    function automatic void scroll_up(input int rows, input int cols);
        for (int y = 2; y < rows; y++)
            for (int x = 0; x < cols; x++)
                text_cells[y-1][x] = text_cells[y][x];
        for (int x = 0; x < cols; x++)
            text_cells[rows-1][x] = tcc_pkg::BLANK_CELL;
        cur_row = rows - 1;
        cur_col = 0;
    endfunction

    function automatic tcc_pkg::result_t console_step(input console_req_t rq);
        tcc_pkg::result_t r;
        int               rows;
        int               cols;
        int               pr;
        int               pc;
        r = '0;
        rows = eff_rows();
        cols = eff_cols();
        case (rq.cmd)
            tcc_pkg::CMD_PRINT:
            begin
                if (rq.ch == tcc_pkg::NEWLINE)
                begin
                    cur_row++;
                    cur_col = 0;
                    if (cur_row >= rows)
                    begin
                        scroll_up(rows, cols);
                        r.scrolled = 1'b1;
                    end
                end
                else
                begin
                    if (cur_col >= cols)
                    begin
                        cur_col = 0;
                        cur_row++;
                        if (cur_row >= rows)
                        begin
                            scroll_up(rows, cols);
                            r.scrolled = 1'b1;
                        end
                    end
                    if (cur_row < rows && cur_col < tcc_pkg::MAX_COLS)
                    begin
                        text_cells[cur_row][cur_col] = {tcc_pkg::TEXT_ATTR, rq.ch};
                        cur_col++;
                    end
                end
            end
            tcc_pkg::CMD_CLEAR:
            begin
                for (int y = 1; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        text_cells[y][x] = tcc_pkg::BLANK_CELL;
                cur_row = 1;
                cur_col = 0;
            end
            tcc_pkg::CMD_READ:
            begin
                if (rq.rr < tcc_pkg::MAX_ROWS && rq.rc < tcc_pkg::MAX_COLS)
                begin
                    r.cell_char = text_cells[rq.rr][rq.rc][7:0];
                    r.cell_attr = text_cells[rq.rr][rq.rc][15:8];
                end
            end
            default: ;
        endcase
        pr = (cur_row >= rows) ? rows - 1 : cur_row;
        pc = (cur_col >= cols) ? cols - 1 : cur_col;
        r.cursor_row = tcc_pkg::ROW_W'(cur_row);
        r.cursor_col = tcc_pkg::COL_W'(cur_col);
        r.cursor_position = tcc_pkg::POS_W'(pr * tcc_pkg::MAX_COLS + pc);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 60)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_report(input tcc_pkg::result_t got);
        tcc_pkg::result_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch($sformatf("unexpected report %h", got));
            return;
        end
        want = expected_reports.pop_front();
        outstanding--;
        if (got.cursor_row != want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, want %0d",
                                      got.cursor_row, want.cursor_row));
        if (got.cursor_col != want.cursor_col)
            report_mismatch($sformatf("cursor_col %0d, want %0d",
                                      got.cursor_col, want.cursor_col));
        if (got.cursor_position != want.cursor_position)
            report_mismatch($sformatf("cursor_position %0d, want %0d",
                                      got.cursor_position, want.cursor_position));
        if (got.cell_char != want.cell_char)
            report_mismatch($sformatf("cell_char %h, want %h",
                                      got.cell_char, want.cell_char));
        if (got.cell_attr != want.cell_attr)
            report_mismatch($sformatf("cell_attr %h, want %h",
                                      got.cell_attr, want.cell_attr));
        if (got.scrolled != want.scrolled)
            report_mismatch($sformatf("scrolled %0d, want %0d",
                                      got.scrolled, want.scrolled));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= tcc_pkg::CMD_NOP;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_reports.push_back(console_step(cur_req));
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    outstanding++;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {4'b0, cur_req.rc, cur_req.rr, cur_req.ch};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_report(tcc_pkg::result_t'(m_tdata));
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic write_reg(input tcc_pkg::reg_idx_t idx,
                             input logic [tcc_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == tcc_pkg::REG_ROWS)
            rows_cfg = val[tcc_pkg::ROW_W-1:0];
        else
            cols_cfg = val;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || outstanding != 0)
            @(posedge clk);
    endtask

    function automatic void push_req(input tcc_pkg::cmd_t cmd, input logic [7:0] ch,
                                     input logic [4:0] rr, input logic [6:0] rc);
        console_req_t rq;
        rq.cmd = cmd;
        rq.ch  = ch;
        rq.rr  = rr;
        rq.rc  = rc;
        pending_reqs.push_back(rq);
    endfunction

    function automatic console_req_t random_req();
        console_req_t rq;
        int           pick;
        pick  = $urandom_range(99);
        rq.ch = tcc_pkg::CHAR_W'($urandom_range(255));
        rq.rr = tcc_pkg::ROW_W'($urandom_range(31));
        rq.rc = tcc_pkg::COL_W'($urandom_range(127));
        if (pick < 70)
        begin
            rq.cmd = tcc_pkg::CMD_PRINT;
            if ($urandom_range(99) < 15)
                rq.ch = tcc_pkg::NEWLINE;
        end
        else if (pick < 74)
            rq.cmd = tcc_pkg::CMD_CLEAR;
        else if (pick < 94)
        begin
            rq.cmd = tcc_pkg::CMD_READ;
            if ($urandom_range(99) < 75)
            begin
                rq.rr = tcc_pkg::ROW_W'($urandom_range(eff_rows() - 1));
                rq.rc = tcc_pkg::COL_W'($urandom_range(eff_cols() - 1));
            end
        end
        else
            rq.cmd = tcc_pkg::CMD_NOP;
        return rq;
    endfunction

    initial
    begin
        #64_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [tcc_pkg::CFG_W-1:0] rows_val;
        logic [tcc_pkg::CFG_W-1:0] cols_val;
        int                        n_items;
        for (int y = 0; y < tcc_pkg::MAX_ROWS; y++)
            for (int x = 0; x < tcc_pkg::MAX_COLS; x++)
                text_cells[y][x] = tcc_pkg::BLANK_CELL;
        cur_row  = 1;
        cur_col  = 0;
        rows_cfg = tcc_pkg::RESET_ROWS;
        cols_cfg = tcc_pkg::RESET_COLS;
        src_idle_pct  = 13;
        sink_idle_pct = 57;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full-size geometry straight out of reset
        push_req(tcc_pkg::CMD_PRINT, 8'h41, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, 8'h00, 5'd31, 7'd127);
        push_req(tcc_pkg::CMD_PRINT, 8'hFF, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'hFF, 5'd1, 7'd2);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd24, 7'd79);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd25, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd31, 7'd127);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd0, 7'd80);
        push_req(tcc_pkg::CMD_NOP, 8'hAA, 5'd21, 7'd85);
        push_req(tcc_pkg::CMD_PRINT, tcc_pkg::NEWLINE, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, tcc_pkg::NEWLINE, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, tcc_pkg::NEWLINE, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, 8'h55, 5'd0, 7'd0);
        wait_idle();

        // shrink below the cursor: drop a byte, scroll on newline, wrap
        write_reg(tcc_pkg::REG_ROWS, 7'd3);
        write_reg(tcc_pkg::REG_COLS, 7'd2);
        push_req(tcc_pkg::CMD_PRINT, 8'h78, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, tcc_pkg::NEWLINE, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, 8'h61, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, 8'h62, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_PRINT, 8'h63, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd1, 7'd1);
        push_req(tcc_pkg::CMD_CLEAR, 8'h00, 5'd0, 7'd0);
        push_req(tcc_pkg::CMD_READ, 8'h00, 5'd2, 7'd0);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 3)
            begin
                src_idle_pct  = 13;
                sink_idle_pct = 57;
            end
            else if (phase < 6)
            begin
                src_idle_pct  = 57;
                sink_idle_pct = 13;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (phase)
                0:
                begin
                    rows_val = 7'd0;
                    cols_val = 7'd127;
                end
                1:
                begin
                    rows_val = 7'd4;
                    cols_val = 7'd1;
                end
                2:
                begin
                    rows_val = 7'd31;
                    cols_val = 7'd6;
                end
                3:
                begin
                    rows_val = 7'd6;
                    cols_val = 7'd12;
                end
                4:
                begin
                    rows_val = 7'd25;
                    cols_val = 7'd80;
                end
                5:
                begin
                    rows_val = 7'd100;
                    cols_val = 7'd0;
                end
                default:
                begin
                    rows_val = tcc_pkg::CFG_W'($urandom_range(8, 2));
                    cols_val = tcc_pkg::CFG_W'($urandom_range(20, 1));
                end
            endcase
            write_reg(tcc_pkg::REG_ROWS, rows_val);
            write_reg(tcc_pkg::REG_COLS, cols_val);
            n_items = (phase == 4) ? 60 : 100;
            repeat (n_items)
                pending_reqs.push_back(random_req());
            wait_idle();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
